// ----- rtl/core/message_dedup_table_with_aging_unit_defines.svh -----
// ----------------------------------------------------------------------------
// message dedup table assertion macros
// shared property shapes for the dedup filter checks
// ----------------------------------------------------------------------------
`ifndef MESSAGE_DEDUP_TABLE_WITH_AGING_UNIT_DEFINES_SVH
`define MESSAGE_DEDUP_TABLE_WITH_AGING_UNIT_DEFINES_SVH

// same-cycle implication
`define MDT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MDT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/mdt_pkg.sv -----
// ----------------------------------------------------------------------------
// mdt_pkg
// shared constants, types and codes of the message dedup filter
// ----------------------------------------------------------------------------
package mdt_pkg;

   localparam int SHORT_ENTRIES = 64;
   localparam int EXT_ENTRIES   = 64;
   localparam int MAX_ENTRIES   = (SHORT_ENTRIES > EXT_ENTRIES) ? SHORT_ENTRIES : EXT_ENTRIES;

   localparam int SHORT_IDX_W = $clog2(SHORT_ENTRIES);
   localparam int EXT_IDX_W   = $clog2(EXT_ENTRIES);
   localparam int SWEEP_W     = $clog2(MAX_ENTRIES);

   localparam int SHORT_KEY_W = 56;
   localparam int EXT_HI_W    = 48;
   localparam int EXT_LO_W    = 64;
   localparam int TIME_W      = 48;
   localparam int AGE_W       = 32;
   localparam int CNT_W       = 7;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_AGE_SHORT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_AGE_EXT   = 1'b1;

   localparam logic [AGE_W-1:0] MAX_AGE_RESET = 32'd1000000;

   localparam logic REQ_CHECK = 1'b0;
   localparam logic REQ_CLEAN = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_DRAIN,
      ST_UPDATE,
      ST_FINISH
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;    // capture the accepted request, restart the sweep
      logic sweep;   // read one table entry and advance the index
      logic commit;  // insert a new key when the check missed and a slot is free
      logic finish;  // load the response register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic sweep_last;
   } status_type;

endpackage

// ----- rtl/core/mdt_ctrl.sv -----
// ----------------------------------------------------------------------------
// mdt_ctrl
// sequencer for lookup, aging sweep, insert and response handoff
// ----------------------------------------------------------------------------
module mdt_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   input  mdt_pkg::status_type status,
   output mdt_pkg::cmd_type    cmd
);

   mdt_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mdt_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         mdt_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = mdt_pkg::ST_SWEEP;
            end
         end
         mdt_pkg::ST_SWEEP: begin
            cmd.sweep = 1'b1;
            if (status.sweep_last) begin
               state_in = mdt_pkg::ST_DRAIN;
            end
         end
         mdt_pkg::ST_DRAIN: begin
            // last entry is compared in this cycle
            state_in = mdt_pkg::ST_UPDATE;
         end
         mdt_pkg::ST_UPDATE: begin
            cmd.commit = 1'b1;
            state_in   = mdt_pkg::ST_FINISH;
         end
         mdt_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.finish = 1'b1;
               state_in   = mdt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mdt_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.finish | (rsp_valid_ff & rsp_stall);
   assign rsp_valid    = rsp_valid_ff;
   assign req_stall    = (state_ff != mdt_pkg::ST_IDLE);

endmodule

// ----- rtl/core/mdt_dpath.sv -----
// ----------------------------------------------------------------------------
// mdt_dpath
// message tables, valid bits, sweep pipeline, age limits and response register
// ----------------------------------------------------------------------------
module mdt_dpath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  mdt_pkg::cmd_type                     cmd,
   output mdt_pkg::status_type                  status,
   input  logic                                 csr_wr_en,
   input  logic [mdt_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [mdt_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic                                 req_type,
   input  logic                                 req_is_extended,
   input  logic [mdt_pkg::EXT_HI_W-1:0]         req_msg_hi,
   input  logic [mdt_pkg::EXT_LO_W-1:0]         req_msg_lo,
   input  logic [mdt_pkg::TIME_W-1:0]           req_time_us,
   output logic                                 rsp_is_duplicate,
   output logic                                 rsp_was_stored,
   output logic                                 rsp_table_full,
   output logic [mdt_pkg::CNT_W-1:0]            rsp_removed_short,
   output logic [mdt_pkg::CNT_W-1:0]            rsp_removed_extended
);

   localparam int SW_W = mdt_pkg::SHORT_KEY_W + mdt_pkg::TIME_W;
   localparam int EW_W = mdt_pkg::EXT_HI_W + mdt_pkg::EXT_LO_W + mdt_pkg::TIME_W;
   localparam logic [mdt_pkg::CNT_W-1:0] CNT_MAX = '1;

   // age limits
   logic [mdt_pkg::AGE_W-1:0] max_age_short_ff;
   logic [mdt_pkg::AGE_W-1:0] max_age_ext_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_age_short_ff <= mdt_pkg::MAX_AGE_RESET;
         max_age_ext_ff   <= mdt_pkg::MAX_AGE_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            mdt_pkg::CSR_MAX_AGE_SHORT: max_age_short_ff <= csr_wdata;
            mdt_pkg::CSR_MAX_AGE_EXT:   max_age_ext_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // captured request
   logic                         op_ff;
   logic                         ext_ff;
   logic [mdt_pkg::EXT_HI_W-1:0] hi_ff;
   logic [mdt_pkg::EXT_LO_W-1:0] lo_ff;
   logic [mdt_pkg::TIME_W-1:0]   now_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_type;
         ext_ff <= req_is_extended;
         hi_ff  <= req_msg_hi;
         lo_ff  <= req_msg_lo;
         now_ff <= req_time_us;
      end
   end

   // sweep index and compare stage tag
   logic [mdt_pkg::SWEEP_W-1:0] idx_ff;
   logic [mdt_pkg::SWEEP_W-1:0] cmp_idx_ff;
   logic                        cmp_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_vld_ff <= 1'b0;
      end else begin
         cmp_vld_ff <= cmd.sweep;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         idx_ff <= '0;
      end else if (cmd.sweep) begin
         idx_ff <= idx_ff + 1'b1;
      end
      cmp_idx_ff <= idx_ff;
   end

   assign status.sweep_last = (idx_ff == mdt_pkg::SWEEP_W'(mdt_pkg::MAX_ENTRIES - 1));

   // table memories: {key, time} per entry
   logic [SW_W-1:0] short_mem [mdt_pkg::SHORT_ENTRIES];
   logic [EW_W-1:0] ext_mem   [mdt_pkg::EXT_ENTRIES];
   logic [SW_W-1:0] short_rd_ff;
   logic [EW_W-1:0] ext_rd_ff;

   logic                        dup_ff;
   logic                        free_found_ff;
   logic [mdt_pkg::SWEEP_W-1:0] free_idx_ff;
   logic                        insert;
   logic                        short_we;
   logic                        ext_we;

   assign insert   = cmd.commit && (op_ff == mdt_pkg::REQ_CHECK) && !dup_ff && free_found_ff;
   assign short_we = insert && !ext_ff;
   assign ext_we   = insert && ext_ff;

   always_ff @(posedge clock) begin
      if (cmd.sweep) begin
         short_rd_ff <= short_mem[idx_ff[mdt_pkg::SHORT_IDX_W-1:0]];
      end
      if (short_we) begin
         short_mem[free_idx_ff[mdt_pkg::SHORT_IDX_W-1:0]] <=
            {lo_ff[mdt_pkg::SHORT_KEY_W-1:0], now_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sweep) begin
         ext_rd_ff <= ext_mem[idx_ff[mdt_pkg::EXT_IDX_W-1:0]];
      end
      if (ext_we) begin
         ext_mem[free_idx_ff[mdt_pkg::EXT_IDX_W-1:0]] <= {hi_ff, lo_ff, now_ff};
      end
   end

   // compare stage
   logic [mdt_pkg::SHORT_ENTRIES-1:0] short_valid_ff;
   logic [mdt_pkg::EXT_ENTRIES-1:0]   ext_valid_ff;

   logic                       s_active, e_active;
   logic                       s_vbit, e_vbit;
   logic                       s_hit, e_hit;
   logic                       s_aged, e_aged;
   logic [mdt_pkg::TIME_W-1:0] s_age, e_age;
   logic                       is_check, is_clean;
   logic                       t_active, t_vbit, t_hit;
   logic                       s_remove, e_remove;

   assign is_check = cmp_vld_ff && (op_ff == mdt_pkg::REQ_CHECK);
   assign is_clean = cmp_vld_ff && (op_ff == mdt_pkg::REQ_CLEAN);

   assign s_active = cmp_idx_ff <= mdt_pkg::SWEEP_W'(mdt_pkg::SHORT_ENTRIES - 1);
   assign e_active = cmp_idx_ff <= mdt_pkg::SWEEP_W'(mdt_pkg::EXT_ENTRIES - 1);
   assign s_vbit   = s_active && short_valid_ff[cmp_idx_ff[mdt_pkg::SHORT_IDX_W-1:0]];
   assign e_vbit   = e_active && ext_valid_ff[cmp_idx_ff[mdt_pkg::EXT_IDX_W-1:0]];

   assign s_hit = short_rd_ff[SW_W-1:mdt_pkg::TIME_W] == lo_ff[mdt_pkg::SHORT_KEY_W-1:0];
   assign e_hit = ext_rd_ff[EW_W-1:mdt_pkg::TIME_W] == {hi_ff, lo_ff};

   // age wraps modulo the timestamp width
   assign s_age  = now_ff - short_rd_ff[mdt_pkg::TIME_W-1:0];
   assign e_age  = now_ff - ext_rd_ff[mdt_pkg::TIME_W-1:0];
   assign s_aged = s_age > mdt_pkg::TIME_W'(max_age_short_ff);
   assign e_aged = e_age > mdt_pkg::TIME_W'(max_age_ext_ff);

   assign t_active = ext_ff ? e_active : s_active;
   assign t_vbit   = ext_ff ? e_vbit   : s_vbit;
   assign t_hit    = ext_ff ? e_hit    : s_hit;

   assign s_remove = is_clean && s_vbit && s_aged;
   assign e_remove = is_clean && e_vbit && e_aged;

   always_ff @(posedge clock) begin
      if (reset) begin
         short_valid_ff <= '0;
         ext_valid_ff   <= '0;
      end else begin
         if (s_remove) begin
            short_valid_ff[cmp_idx_ff[mdt_pkg::SHORT_IDX_W-1:0]] <= 1'b0;
         end
         if (e_remove) begin
            ext_valid_ff[cmp_idx_ff[mdt_pkg::EXT_IDX_W-1:0]] <= 1'b0;
         end
         if (short_we) begin
            short_valid_ff[free_idx_ff[mdt_pkg::SHORT_IDX_W-1:0]] <= 1'b1;
         end
         if (ext_we) begin
            ext_valid_ff[free_idx_ff[mdt_pkg::EXT_IDX_W-1:0]] <= 1'b1;
         end
      end
   end

   logic [mdt_pkg::CNT_W-1:0] rs_ff, re_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         dup_ff        <= 1'b0;
         free_found_ff <= 1'b0;
         free_idx_ff   <= '0;
         rs_ff         <= '0;
         re_ff         <= '0;
      end else begin
         if (is_check && t_active) begin
            if (t_vbit) begin
               if (t_hit) begin
                  dup_ff <= 1'b1;
               end
            end else if (!free_found_ff) begin
               // lowest free slot wins
               free_found_ff <= 1'b1;
               free_idx_ff   <= cmp_idx_ff;
            end
         end
         if (s_remove && rs_ff != CNT_MAX) begin
            rs_ff <= rs_ff + 1'b1;
         end
         if (e_remove && re_ff != CNT_MAX) begin
            re_ff <= re_ff + 1'b1;
         end
      end
   end

   // response register
   logic                      rsp_dup_ff, rsp_stored_ff, rsp_full_ff;
   logic [mdt_pkg::CNT_W-1:0] rsp_rs_ff, rsp_re_ff;
   logic                      chk_done;

   assign chk_done = (op_ff == mdt_pkg::REQ_CHECK);

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_dup_ff    <= chk_done && dup_ff;
         rsp_stored_ff <= chk_done && !dup_ff && free_found_ff;
         rsp_full_ff   <= chk_done && !dup_ff && !free_found_ff;
         rsp_rs_ff     <= rs_ff;
         rsp_re_ff     <= re_ff;
      end
   end

   assign rsp_is_duplicate     = rsp_dup_ff;
   assign rsp_was_stored       = rsp_stored_ff;
   assign rsp_table_full       = rsp_full_ff;
   assign rsp_removed_short    = rsp_rs_ff;
   assign rsp_removed_extended = rsp_re_ff;

endmodule

// ----- rtl/core/message_dedup_table_with_aging_unit.sv -----
// Duplicate message filter with time-windowed aging. A check request looks up a
// 56-bit short or 112-bit extended message in the table of its kind (64 entries
// each), reports a duplicate on an exact match, and otherwise stores it with its
// timestamp in the lowest free slot or flags the table as full. A clean request
// drops every entry older than its kind's age limit (csr index 0 short, 1
// extended, both 1000000 us after reset) and returns how many were removed.
// A request is worked through in order before the next one is accepted: the
// tables sit in single-read-port memories and are swept one entry per cycle,
// then the last entry is compared, a new key is inserted, the response is loaded
// and the block returns to idle, where the next request is accepted. A waiting
// response does not hold the sweep; only the response load waits for it.
// Valid bits are flops cleared by reset, so there is no clearing pass.

`include "message_dedup_table_with_aging_unit_defines.svh"

// ----------------------------------------------------------------------------
// message_dedup_table_with_aging_unit
// top level: controller and datapath of the duplicate message filter
// ----------------------------------------------------------------------------
module message_dedup_table_with_aging_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [mdt_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mdt_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_type,
   input  logic                              req_is_extended,
   input  logic [mdt_pkg::EXT_HI_W-1:0]      req_msg_hi,
   input  logic [mdt_pkg::EXT_LO_W-1:0]      req_msg_lo,
   input  logic [mdt_pkg::TIME_W-1:0]        req_time_us,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_is_duplicate,
   output logic                              rsp_was_stored,
   output logic                              rsp_table_full,
   output logic [mdt_pkg::CNT_W-1:0]         rsp_removed_short,
   output logic [mdt_pkg::CNT_W-1:0]         rsp_removed_extended
);

   mdt_pkg::cmd_type    cmd;
   mdt_pkg::status_type status;

   mdt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   mdt_dpath u_dpath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .csr_wr_en            (csr_wr_en),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .req_type             (req_type),
      .req_is_extended      (req_is_extended),
      .req_msg_hi           (req_msg_hi),
      .req_msg_lo           (req_msg_lo),
      .req_time_us          (req_time_us),
      .rsp_is_duplicate     (rsp_is_duplicate),
      .rsp_was_stored       (rsp_was_stored),
      .rsp_table_full       (rsp_table_full),
      .rsp_removed_short    (rsp_removed_short),
      .rsp_removed_extended (rsp_removed_extended)
   );

   // a request is being worked on after acceptance
   `MDT_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall,
                    "request accepted but block not busy")

   // a loaded response is presented next cycle
   `MDT_ASSERT_NEXT(a_finish_shows_rsp, clock, reset, cmd.finish, rsp_valid,
                    "response load did not raise valid")

   // check outcomes are exclusive
   `MDT_ASSERT_SAME(a_check_exclusive, clock, reset, rsp_valid,
                    $onehot0({rsp_is_duplicate, rsp_was_stored, rsp_table_full}),
                    "conflicting check outcome")

   // removal counts belong to clean responses only
   `MDT_ASSERT_SAME(a_clean_no_flags, clock, reset,
                    rsp_valid && (rsp_removed_short != '0 || rsp_removed_extended != '0),
                    !(rsp_is_duplicate || rsp_was_stored || rsp_table_full),
                    "clean response carries check flags")

endmodule
